// ===== hdl/smt_pkg.sv =====
`timescale 1ns / 1ps

package smt_pkg;

  localparam int CAPACITY = 1024;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] KEY_MAX = 32'sh7FFF_FFFF;

  localparam logic [1:0] KIND_LOOKUP = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_PROBE_RD,
    ST_PROBE_CMP,
    ST_DECIDE,
    ST_SHIFT_CHK,
    ST_SHIFT_WR,
    ST_TAIL_RD,
    ST_TAIL_CAP
  } state_t;

  typedef enum logic [1:0] {
    RSEL_SRCH,
    RSEL_PROBE,
    RSEL_SHIFT,
    RSEL_TAIL
  } rsel_t;

  typedef struct packed {
    logic  load;
    logic  search_step;
    logic  capture;
    logic  shift_init;
    logic  shift_write;
    logic  commit;
    logic  out_load;
    rsel_t rsel;
  } cmd_t;

  typedef struct packed {
    logic search_done;
    logic modify;
    logic shift_more;
    logic out_free;
  } sts_t;

endpackage

// ===== hdl/smt_ctrl.sv =====
`timescale 1ns / 1ps

module smt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  smt_pkg::sts_t sts,
  output smt_pkg::cmd_t cmd
);
  import smt_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (s_tvalid) state_next = ST_SRCH_RD;
      ST_SRCH_RD:   state_next = sts.search_done ? ST_PROBE_RD : ST_SRCH_CMP;
      ST_SRCH_CMP:  state_next = ST_SRCH_RD;
      ST_PROBE_RD:  state_next = ST_PROBE_CMP;
      ST_PROBE_CMP: state_next = ST_DECIDE;
      ST_DECIDE:    state_next = sts.modify ? ST_SHIFT_CHK : ST_TAIL_RD;
      ST_SHIFT_CHK: state_next = sts.shift_more ? ST_SHIFT_WR : ST_TAIL_RD;
      ST_SHIFT_WR:  state_next = ST_SHIFT_CHK;
      ST_TAIL_RD:   state_next = ST_TAIL_CAP;
      ST_TAIL_CAP:  if (sts.out_free) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.rsel = RSEL_SRCH;
    s_tready = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      ST_SRCH_RD:   cmd.rsel = RSEL_SRCH;
      ST_SRCH_CMP:  cmd.search_step = 1'b1;
      ST_PROBE_RD:  cmd.rsel = RSEL_PROBE;
      ST_PROBE_CMP: begin
        cmd.rsel    = RSEL_PROBE;
        cmd.capture = 1'b1;
      end
      ST_DECIDE:    cmd.shift_init = sts.modify;
      ST_SHIFT_CHK: begin
        cmd.rsel   = RSEL_SHIFT;
        cmd.commit = !sts.shift_more;
      end
      ST_SHIFT_WR:  cmd.shift_write = 1'b1;
      ST_TAIL_RD:   cmd.rsel = RSEL_TAIL;
      ST_TAIL_CAP: begin
        cmd.rsel     = RSEL_TAIL;
        cmd.out_load = sts.out_free;
      end
      default: ;
    endcase
  end

endmodule

// ===== hdl/smt_datapath.sv =====
`timescale 1ns / 1ps

module smt_datapath (
  input  logic          clk,
  input  logic          rst,
  input  logic [31:0]   s_tdata,
  input  logic [1:0]    s_tuser,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [135:0]  m_tdata,
  input  smt_pkg::cmd_t cmd,
  output smt_pkg::sts_t sts
);
  import smt_pkg::*;

  logic [31:0] mem [CAPACITY];

  logic signed [31:0] key;
  logic [1:0]         kind;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   la, ha, lb, hb, ptr;
  logic               found, full, do_ins, do_rem;
  logic signed [31:0] fl, ce;
  logic signed [31:0] rdata_a, rdata_b;

  logic               o_found, o_empty, o_full;
  logic signed [31:0] o_fl, o_ce, o_small, o_large;

  logic [CNT_W:0]     sum_a, sum_b, ptr_inc;
  logic [CNT_W-1:0]   mid_a, mid_b, lb_dec, cnt_dec;
  logic [IDX_W-1:0]   addr_a, addr_b, waddr;
  logic [31:0]        wdata;
  logic               we, sentinel, found_now;

  assign sum_a    = {1'b0, la} + {1'b0, ha};
  assign sum_b    = {1'b0, lb} + {1'b0, hb};
  assign mid_a    = sum_a[CNT_W:1];
  assign mid_b    = sum_b[CNT_W:1];
  assign lb_dec   = lb - 1'b1;
  assign cnt_dec  = count - 1'b1;
  assign ptr_inc  = {1'b0, ptr} + 1'b1;
  assign sentinel = (key == KEY_MIN) || (key == KEY_MAX);
  assign found_now = !sentinel && (la < count) && (rdata_a == key);

  always_comb begin
    case (cmd.rsel)
      RSEL_SRCH: begin
        addr_a = mid_a[IDX_W-1:0];
        addr_b = mid_b[IDX_W-1:0];
      end
      RSEL_PROBE: begin
        addr_a = la[IDX_W-1:0];
        addr_b = lb_dec[IDX_W-1:0];
      end
      RSEL_SHIFT: begin
        addr_a = do_ins ? (ptr[IDX_W-1:0] - 1'b1) : ptr_inc[IDX_W-1:0];
        addr_b = '0;
      end
      RSEL_TAIL: begin
        addr_a = '0;
        addr_b = cnt_dec[IDX_W-1:0];
      end
      default: begin
        addr_a = '0;
        addr_b = '0;
      end
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = ptr[IDX_W-1:0];
    wdata = rdata_a;
    if (cmd.shift_write) begin
      we = 1'b1;
    end else if (cmd.commit && do_ins) begin
      we    = 1'b1;
      waddr = lb[IDX_W-1:0];
      wdata = key;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[addr_a];
    rdata_b <= mem[addr_b];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key  <= s_tdata;
      kind <= s_tuser;
      la   <= '0;
      ha   <= count;
      lb   <= '0;
      hb   <= count;
    end
    if (cmd.search_step) begin
      if (la < ha) begin
        if (rdata_a < key) la <= mid_a + 1'b1;
        else               ha <= mid_a;
      end
      if (lb < hb) begin
        if (rdata_b <= key) lb <= mid_b + 1'b1;
        else                hb <= mid_b;
      end
    end
    if (cmd.capture) begin
      found  <= found_now;
      fl     <= (lb != '0) ? rdata_b : KEY_MIN;
      ce     <= (la < count) ? rdata_a : KEY_MAX;
      full   <= (kind == KIND_INSERT) && (count == CNT_W'(CAPACITY));
      do_ins <= (kind == KIND_INSERT) && (count != CNT_W'(CAPACITY)) && !sentinel;
      do_rem <= (kind == KIND_REMOVE) && found_now;
    end
    if (cmd.shift_init) begin
      ptr <= do_ins ? count : la;
    end
    if (cmd.shift_write) begin
      ptr <= do_ins ? (ptr - 1'b1) : ptr_inc[CNT_W-1:0];
    end
    if (cmd.out_load) begin
      o_found <= found;
      o_fl    <= fl;
      o_ce    <= ce;
      o_small <= (count != '0) ? rdata_a : KEY_MAX;
      o_large <= (count != '0) ? rdata_b : KEY_MIN;
      o_empty <= (count == '0);
      o_full  <= full;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.commit && do_ins) count <= count + 1'b1;
      else if (cmd.commit && do_rem) count <= cnt_dec;
      if (cmd.out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  assign sts.search_done = (la >= ha) && (lb >= hb);
  assign sts.modify      = do_ins || do_rem;
  assign sts.shift_more  = do_ins ? (ptr > lb) : (ptr_inc < {1'b0, count});
  assign sts.out_free    = !m_tvalid || m_tready;

  assign m_tdata = {5'b0, o_full, o_empty, o_large, o_small, o_ce, o_fl, o_found};

endmodule

// ===== hdl/sorted_multiset_table_core.sv =====
`timescale 1ns / 1ps
// Channel | Dir | Fields (lowest bit up)
// s_*     | in  | tdata: value[31:0]; tuser: kind[1:0]
// m_*     | out | tdata: found, floor_value, ceiling_value, smallest, largest,
//         |     |       is_empty, full_error, zero pad to 136 bits
// A request runs a binary search over the dual-read memory, then probe reads,
// then shifts the entries moved by an insert or remove, then tail reads.
// One request is in flight; s_tready is high only while idle.
// rst is synchronous and empties the store; memory contents are not cleared.
// A stalled result holds in the output register until m_tready.

module sorted_multiset_table_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [31:0]  s_tdata,   // value
  input  logic [1:0]   s_tuser,   // kind
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [135:0] m_tdata    // found, floor, ceiling, smallest, largest, empty, full
);
  import smt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  smt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  smt_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

// ===== bench/sorted_multiset_table_core_tb.sv =====
`timescale 1ns / 1ps

module sorted_multiset_table_core_tb;
  import smt_pkg::*;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] value;
  } request_t;

  typedef struct packed {
    logic               full_error;
    logic               is_empty;
    logic signed [31:0] largest;
    logic signed [31:0] smallest;
    logic signed [31:0] ceiling_value;
    logic signed [31:0] floor_value;
    logic               found;
  } answer_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [31:0]  s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [135:0] m_tdata;

  sorted_multiset_table_core u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #1 clk = ~clk;

  request_t    pending_q[$];
  answer_t     answer_q[$];
  logic signed [31:0] model_store[$];
  int          fail_count = 0;
  int          sent_count = 0;
  int          offered_count = 0;
  int          got_count = 0;
  int          full_count = 0;
  int          idle_send_pct = 0;
  int          stall_recv_pct = 0;
  int          hold_left = 0;
  int          quiet_cycles = 0;
  bit          hold_start = 1'b0;
  bit          hold_seen = 1'b0;
  bit          send_pause = 1'b0;
  request_t    cur;

  function automatic answer_t apply_request(request_t r);
    answer_t a;
    int n, lo, hi;
    bit sentinel;
    n = model_store.size();
    lo = 0;
    hi = 0;
    sentinel = (r.value == KEY_MIN) || (r.value == KEY_MAX);
    for (int i = 0; i < n; i++) begin
      if (model_store[i] < r.value) lo = i + 1;
      if (model_store[i] <= r.value) hi = i + 1;
    end
    a = '0;
    a.found = !sentinel && lo < n && model_store[lo] == r.value;
    a.floor_value = (hi > 0) ? model_store[hi - 1] : KEY_MIN;
    a.ceiling_value = (lo < n) ? model_store[lo] : KEY_MAX;
    if (r.kind == KIND_INSERT) begin
      if (n >= CAPACITY) a.full_error = 1'b1;
      else if (!sentinel) model_store.insert(hi, r.value);
    end else if (r.kind == KIND_REMOVE && a.found) begin
      model_store.delete(lo);
    end
    n = model_store.size();
    a.smallest = n > 0 ? model_store[0] : KEY_MAX;
    a.largest = n > 0 ? model_store[n - 1] : KEY_MIN;
    a.is_empty = (n == 0);
    return a;
  endfunction

  function automatic request_t make_request(logic [1:0] k, logic signed [31:0] v);
    request_t r;
    r.kind = k;
    r.value = v;
    return r;
  endfunction

  // driver
  always @(negedge clk) begin
    if (!rst) begin
      if (!s_tvalid || sent_count == offered_count) begin
        if (pending_q.size() > 0 && !send_pause &&
            $urandom_range(99) >= idle_send_pct) begin
          cur = pending_q.pop_front();
          s_tdata <= cur.value;
          s_tuser <= cur.kind;
          s_tvalid <= 1'b1;
          offered_count <= offered_count + 1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_start && !hold_seen) begin
        hold_seen <= 1'b1;
        hold_left <= 400;
        m_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= stall_recv_pct);
      end
    end
  end

  // monitor and predictor
  always @(posedge clk) begin
    answer_t got, want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        sent_count <= sent_count + 1;
        answer_q.push_back(apply_request(make_request(s_tuser, s_tdata)));
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata[130:0];
        got_count <= got_count + 1;
        if (answer_q.size() == 0) begin
          $error("unexpected result %h", m_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = answer_q.pop_front();
          if (want.full_error) full_count <= full_count + 1;
          if (got.found !== want.found) begin
            $error("found exp %0d got %0d", want.found, got.found);
            fail_count <= fail_count + 1;
          end
          if (got.floor_value !== want.floor_value) begin
            $error("floor_value exp %0d got %0d", want.floor_value, got.floor_value);
            fail_count <= fail_count + 1;
          end
          if (got.ceiling_value !== want.ceiling_value) begin
            $error("ceiling_value exp %0d got %0d", want.ceiling_value, got.ceiling_value);
            fail_count <= fail_count + 1;
          end
          if (got.smallest !== want.smallest) begin
            $error("smallest exp %0d got %0d", want.smallest, got.smallest);
            fail_count <= fail_count + 1;
          end
          if (got.largest !== want.largest) begin
            $error("largest exp %0d got %0d", want.largest, got.largest);
            fail_count <= fail_count + 1;
          end
          if (got.is_empty !== want.is_empty) begin
            $error("is_empty exp %0d got %0d", want.is_empty, got.is_empty);
            fail_count <= fail_count + 1;
          end
          if (got.full_error !== want.full_error) begin
            $error("full_error exp %0d got %0d", want.full_error, got.full_error);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

  // watchdog for the worst request, which moves 1023 entries
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 40000) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  function automatic logic signed [31:0] rand_key(int spread);
    int r;
    r = $urandom_range(9);
    if (r == 0) return $urandom;
    if (r == 1) return $signed($urandom_range(2147483646)) * ($urandom_range(1) ? -1 : 1);
    return $signed($urandom_range(2 * spread)) - spread;
  endfunction

  task automatic queue_random(int count, int ins_w, int rem_w, int spread);
    logic [1:0] k;
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < ins_w) k = KIND_INSERT;
      else if (r < ins_w + rem_w) k = KIND_REMOVE;
      else k = $urandom_range(1) ? KIND_LOOKUP : 2'd3;
      pending_q.push_back(make_request(k, rand_key(spread)));
    end
  endtask

  task automatic drain;
    wait (pending_q.size() == 0);
    while (s_tvalid || answer_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    pending_q.push_back(make_request(KIND_LOOKUP, 32'sd0));
    pending_q.push_back(make_request(KIND_REMOVE, 32'sd5));
    pending_q.push_back(make_request(KIND_INSERT, KEY_MIN));
    pending_q.push_back(make_request(KIND_INSERT, KEY_MAX));
    pending_q.push_back(make_request(KIND_INSERT, KEY_MIN + 1));
    pending_q.push_back(make_request(KIND_INSERT, KEY_MAX - 1));
    pending_q.push_back(make_request(KIND_INSERT, 32'sd7));
    pending_q.push_back(make_request(KIND_INSERT, 32'sd7));
    pending_q.push_back(make_request(KIND_INSERT, -32'sd1));
    pending_q.push_back(make_request(KIND_LOOKUP, KEY_MIN));
    pending_q.push_back(make_request(KIND_LOOKUP, KEY_MAX));
    pending_q.push_back(make_request(2'd3, 32'sd7));
    pending_q.push_back(make_request(KIND_LOOKUP, 32'sd3));
    pending_q.push_back(make_request(KIND_REMOVE, 32'sd7));
    pending_q.push_back(make_request(KIND_REMOVE, KEY_MAX));
    pending_q.push_back(make_request(KIND_REMOVE, 32'sd100));
    pending_q.push_back(make_request(KIND_REMOVE, KEY_MIN + 1));
    pending_q.push_back(make_request(KIND_REMOVE, KEY_MAX - 1));
    pending_q.push_back(make_request(KIND_REMOVE, 32'sd7));
    pending_q.push_back(make_request(KIND_REMOVE, -32'sd1));
    pending_q.push_back(make_request(KIND_LOOKUP, -32'sd1));
    drain();

    queue_random(70, 60, 15, 40);
    drain();
    idle_send_pct = 62;
    queue_random(70, 55, 20, 60);
    drain();
    idle_send_pct = 0;
    stall_recv_pct = 62;
    hold_start = 1'b1;
    queue_random(70, 55, 20, 1000);
    drain();
    idle_send_pct = 32;
    stall_recv_pct = 32;
    queue_random(70, 50, 25, 50);
    drain();

    // fill to capacity, then hammer the full store
    idle_send_pct = 0;
    stall_recv_pct = 0;
    send_pause = 1'b1;
    queue_random(CAPACITY - model_store.size(), 100, 0, 100000);
    queue_random(40, 60, 10, 100000);
    send_pause = 1'b0;
    drain();
    // pause until the full store settles, then send mostly remove requests
    queue_random(100, 5, 80, 100000);
    drain();

    $display("Covered %0d requests and %0d results over idle/stall phases,",
             sent_count, got_count);
    $display("  %0d full-store inserts, final store size %0d.",
             full_count, model_store.size());
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
